/* rtl/core/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the dense layer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, switched off while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/dlr_pkg.sv */
// Shared types and constants of the dense layer with ReLU.
`default_nettype none

package dlr_pkg;

  localparam int unsigned ValueWidth   = 16;
  localparam int unsigned SumWidth     = 40;
  localparam int unsigned FeatureWidth = 15;

  typedef enum logic [1:0] {
    OP_LOAD_WEIGHT = 2'd0,
    OP_LOAD_BIAS   = 2'd1,
    OP_SAMPLE      = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  // Write strobes and data for the weight and bias stores.
  typedef struct packed {
    logic                         wr_weight;
    logic                         wr_bias;
    logic signed [ValueWidth-1:0] data;
  } load_t;

  // Multiply-accumulate control for one neuron step.
  typedef struct packed {
    logic                         valid;
    logic                         first;
    logic signed [ValueWidth-1:0] value;
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
  } acc_status_t;

  typedef struct packed {
    logic [FeatureWidth-1:0] feature;
    logic                    active;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/dlr_store.sv */
// Weight and bias memories of the dense layer, one write and one read port each.
`default_nettype none

module dlr_store #(
  parameter int NUM_NEURONS = 64,
  parameter int MAX_INPUTS  = 256,
  localparam int NW    = (NUM_NEURONS > 1) ? $clog2(NUM_NEURONS) : 1,
  localparam int RW    = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1,
  localparam int DEPTH = NUM_NEURONS * MAX_INPUTS,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire                         clk,
  input  dlr_pkg::load_t              load,
  input  wire  [RW-1:0]               ld_row,
  input  wire  [NW-1:0]               ld_neuron,
  input  wire  [RW-1:0]               rd_row,
  input  wire  [NW-1:0]               rd_neuron,
  output logic signed [15:0]          weight_q,
  output logic signed [15:0]          bias_q
);
  import dlr_pkg::*;

  logic signed [ValueWidth-1:0] weight_mem [DEPTH];
  logic signed [ValueWidth-1:0] bias_mem [NUM_NEURONS];

  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  // Row-major layout: one row of NUM_NEURONS weights per input position.
  assign wr_addr = AW'(int'(ld_row) * NUM_NEURONS + int'(ld_neuron));
  assign rd_addr = AW'(int'(rd_row) * NUM_NEURONS + int'(rd_neuron));

  always_ff @(posedge clk) begin
    if (load.wr_weight) begin
      weight_mem[wr_addr] <= load.data;
    end
    weight_q <= weight_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (load.wr_bias) begin
      bias_mem[ld_neuron] <= load.data;
    end
    bias_q <= bias_mem[rd_neuron];
  end

endmodule

`default_nettype wire

/* rtl/core/dlr_accum.sv */
// Accumulator memory with the multiply-add pipeline and the ReLU output stage.
`default_nettype none

module dlr_accum #(
  parameter int NUM_NEURONS = 64,
  localparam int NW = (NUM_NEURONS > 1) ? $clog2(NUM_NEURONS) : 1
) (
  input  wire                  clk,
  input  wire                  rst,
  input  dlr_pkg::mac_ctl_t    mac,
  input  wire  [NW-1:0]        neuron,
  input  wire  signed [15:0]   weight_q,
  input  wire  signed [15:0]   bias_q,
  output dlr_pkg::acc_status_t status,
  output dlr_pkg::result_t     result
);
  import dlr_pkg::*;

  logic signed [SumWidth-1:0] sum_mem [NUM_NEURONS];
  logic signed [SumWidth-1:0] sum_q;

  // Stage one: memory data valid. Stage two: product and base registered.
  logic                          v1;
  logic                          v2;
  logic                          first1;
  logic [NW-1:0]                 k1;
  logic [NW-1:0]                 k2;
  logic signed [ValueWidth-1:0]  value1;
  logic signed [2*ValueWidth-1:0] prod;
  logic signed [SumWidth-1:0]    base;
  logic signed [SumWidth-1:0]    sum_new;
  logic signed [SumWidth-1:0]    bias_ext;

  assign bias_ext = {{12{bias_q[15]}}, bias_q, 12'b0};
  assign sum_new  = base + {{(SumWidth - 2*ValueWidth){prod[2*ValueWidth-1]}}, prod};

  always_ff @(posedge clk) begin
    if (v2) begin
      sum_mem[k2] <= sum_new;
    end
    sum_q <= sum_mem[neuron];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= mac.valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    first1 <= mac.first;
    value1 <= mac.value;
    k1     <= neuron;
    k2     <= k1;
    prod   <= value1 * weight_q;
    base   <= first1 ? bias_ext : sum_q;
  end

  assign status.busy = v1 | v2;

  // ReLU on the stored sum, scaled back to unsigned Q3.12 and clipped at the top.
  always_comb begin
    result.feature = '0;
    result.active  = 1'b0;
    if (!sum_q[SumWidth-1] && (sum_q != '0)) begin
      result.active = 1'b1;
      if (|sum_q[SumWidth-2:12+FeatureWidth]) begin
        result.feature = '1;
      end else begin
        result.feature = sum_q[12+FeatureWidth-1:12];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/dense_layer_relu_top.sv */
// Top level of the fully connected layer with ReLU: handshakes, sequencer, register.
`default_nettype none

// A fully connected layer of NUM_NEURONS neurons over up to MAX_INPUTS Q4.12
// inputs. Load beats (tuser 0 for a weight, 1 for a bias) write the stores and
// produce nothing; a load with an out-of-range neuron or input position, and
// tuser 3, are dropped. A sample beat (tuser 2) is taken only while the block
// is idle and then sweeps all neurons through the single read port of the
// accumulator memory, one neuron per cycle. The block then waits until the
// last multiply-add is written back, and returns to idle. The first sample
// of a pass starts every sum from its bias. When inputs_in_use samples have
// been taken (0 counts as 1, values above MAX_INPUTS as MAX_INPUTS), the block
// emits one result beat per neuron in neuron order, and tlast marks the final
// neuron. New input beats are taken again as soon as the last result sits in
// the output register. Weights and biases read before they were ever written
// give undefined results. The register must be written only while the block
// is idle; the block itself does not enforce this.

module dense_layer_relu_top #(
  parameter int NUM_NEURONS = 64,
  parameter int MAX_INPUTS  = 256
) (
  input  wire         clk,
  input  wire         rst,
  // APB register port.
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream.
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // neuron_index[5:0], input_index[13:6], value[29:14]
  input  wire  [1:0]  s_axis_tuser,   // operation[1:0]
  // Result stream.
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,   // feature_value[14:0], active[15], neuron_number[21:16]
  output logic        m_axis_tlast    // last_of_run
);
  `include "assert_macros.svh"
  import dlr_pkg::*;

  localparam int NW = (NUM_NEURONS > 1) ? $clog2(NUM_NEURONS) : 1;
  localparam int RW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam logic [NW-1:0] LastNeuron = NW'(NUM_NEURONS - 1);

  // Register map: inputs_in_use is register 0 at byte address 0.
  localparam logic RegInputsInUse = 1'b0;

  // Input beat fields.
  logic [5:0]                   in_neuron;
  logic [7:0]                   in_pos;
  logic signed [ValueWidth-1:0] in_value;
  logic                         in_accept;

  assign in_neuron = s_axis_tdata[5:0];
  assign in_pos    = s_axis_tdata[13:6];
  assign in_value  = s_axis_tdata[29:14];
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // Configuration register.
  logic [8:0] inputs_in_use;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == RegInputsInUse);

  always_ff @(posedge clk) begin
    if (rst) begin
      inputs_in_use <= 9'd256;
    end else if (cfg_write) begin
      inputs_in_use <= pwdata[8:0];
    end
  end

  assign prdata = (paddr[2] == RegInputsInUse) ? {23'b0, inputs_in_use} : '0;

  // Sequencer state.
  state_t                       state;
  state_t                       state_next;
  logic [NW-1:0]                k;
  logic [RW-1:0]                sample_count;
  logic [RW-1:0]                row;
  logic                         first;
  logic                         end_pass;
  logic signed [ValueWidth-1:0] sample_value;

  logic                         sample_in;
  logic [8:0]                   count_inc;
  logic [8:0]                   pass_len;
  logic                         pass_done;

  assign sample_in = in_accept && (s_axis_tuser == OP_SAMPLE);
  assign count_inc = 9'(sample_count) + 9'd1;

  always_comb begin
    if (inputs_in_use == 9'd0) begin
      pass_len = 9'd1;
    end else if (inputs_in_use > 9'(MAX_INPUTS)) begin
      pass_len = 9'(MAX_INPUTS);
    end else begin
      pass_len = inputs_in_use;
    end
  end

  assign pass_done = (count_inc >= pass_len);

  // Submodule connections.
  load_t       load;
  mac_ctl_t    mac;
  acc_status_t acc_status;
  result_t     result;
  logic signed [ValueWidth-1:0] weight_q;
  logic signed [ValueWidth-1:0] bias_q;

  // Loads go straight into the stores; out-of-range neurons and positions are dropped.
  always_comb begin
    load.data      = in_value;
    load.wr_weight = 1'b0;
    load.wr_bias   = 1'b0;
    if (in_accept) begin
      case (s_axis_tuser)
        OP_LOAD_WEIGHT: begin
          load.wr_weight = ({1'b0, in_neuron} < 7'(NUM_NEURONS))
                        && ({1'b0, in_pos} < 9'(MAX_INPUTS));
        end
        OP_LOAD_BIAS: begin
          load.wr_bias = ({1'b0, in_neuron} < 7'(NUM_NEURONS));
        end
        default: begin
        end
      endcase
    end
  end

  assign mac.valid = (state == ST_MAC);
  assign mac.first = first;
  assign mac.value = sample_value;

  dlr_store #(
    .NUM_NEURONS(NUM_NEURONS),
    .MAX_INPUTS (MAX_INPUTS)
  ) u_store (
    .clk      (clk),
    .load     (load),
    .ld_row   (RW'(in_pos)),
    .ld_neuron(NW'(in_neuron)),
    .rd_row   (row),
    .rd_neuron(k),
    .weight_q (weight_q),
    .bias_q   (bias_q)
  );

  dlr_accum #(
    .NUM_NEURONS(NUM_NEURONS)
  ) u_accum (
    .clk     (clk),
    .rst     (rst),
    .mac     (mac),
    .neuron  (k),
    .weight_q(weight_q),
    .bias_q  (bias_q),
    .status  (acc_status),
    .result  (result)
  );

  // Output register; it parts the result side from the sequencer.
  logic out_load;

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (sample_in) begin
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        if (k == LastNeuron) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last write-back must land before the sums are read again.
        if (!acc_status.busy) begin
          state_next = end_pass ? ST_EMIT_RD : ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        out_load   = 1'b1;
        state_next = (k == LastNeuron) ? ST_IDLE : ST_EMIT_RD;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k            <= '0;
      sample_count <= '0;
      end_pass     <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          k <= '0;
          if (sample_in) begin
            end_pass     <= pass_done;
            sample_count <= pass_done ? '0 : RW'(count_inc);
          end
        end
        ST_MAC: begin
          k <= (k == LastNeuron) ? '0 : k + 1'b1;
        end
        ST_EMIT_LD: begin
          k <= (k == LastNeuron) ? '0 : k + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Sample operands hold for the whole sweep.
  always_ff @(posedge clk) begin
    if (sample_in) begin
      sample_value <= in_value;
      first        <= (sample_count == '0);
      row          <= sample_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {2'b0, 6'(k), result.active, result.feature};
      m_axis_tlast <= (k == LastNeuron);
    end
  end

  // The output register must be free whenever a result is loaded into it.
  `ASSERT_CLK(a_load_into_empty, !(state == ST_EMIT_LD && m_axis_tvalid),
              "result loaded while the output register still holds a beat")
  // A new sample never meets a multiply-add still in flight.
  `ASSERT_CLK(a_sample_when_quiet, sample_in |-> !acc_status.busy,
              "sample accepted while the accumulator pipeline was busy")
  // Results are read out only after the pass has restarted its count.
  `ASSERT_CLK(a_emit_count_clear, (state == ST_EMIT_RD) |-> (sample_count == '0),
              "sample count not cleared while emitting results")

endmodule

`default_nettype wire

/* tb/dense_layer_relu_top_test.sv */
// Self-checking testbench for the dense layer with ReLU: load and sample beats in, features out.
`timescale 1ns / 100ps

module dense_layer_relu_top_test;
  import dlr_pkg::*;

  localparam int N_NEURONS  = 64;
  localparam int MAX_IN     = 256;
  localparam int CLK_HALF   = 10;
  localparam int FEATURE_MAX = 32767;
  // One sample sweeps every neuron and then writes back and returns to idle; a
  // little extra margin is added on top.
  localparam int SETTLE_CYCLES = N_NEURONS + 16;
  // Length of the receiver hold-off that forces the block to back up its input.
  localparam int HOLD_CYCLES = 400;
  localparam logic [2:0] REG_INPUTS_IN_USE = 3'd0;
  // The fourth operation code has no meaning; the block must drop it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // One expected result beat.
  typedef struct packed {
    logic [14:0] feature;
    logic        active;
    logic [5:0]  neuron;
    logic        last;
  } feature_beat_t;

  // Predicts the layer: keeps its own weights, biases and sums, and the queue of
  // feature beats still owed by the block.
  class layer_scoreboard;
    logic signed [15:0] weights [MAX_IN][N_NEURONS];
    bit                 weight_known [MAX_IN][N_NEURONS];
    logic signed [15:0] biases [N_NEURONS];
    bit                 bias_known [N_NEURONS];
    logic signed [39:0] sums [N_NEURONS];
    int unsigned        samples_taken;
    int unsigned        pass_len;
    int unsigned        failures;
    feature_beat_t      expected_features [$];

    function new();
      samples_taken = 0;
      pass_len = MAX_IN;
      failures = 0;
      foreach (sums[k]) sums[k] = '0;
    endfunction

    // A register value of zero counts as one, and values beyond the row count
    // are clamped to it.
    function void set_length(logic [8:0] len);
      if (len == 0) pass_len = 1;
      else if (len > MAX_IN) pass_len = MAX_IN;
      else pass_len = len;
    endfunction

    function int unsigned pending();
      return expected_features.size();
    endfunction

    function void note_beat(logic [1:0] op, logic [5:0] neuron, logic [7:0] pos,
                            logic signed [15:0] value);
      logic signed [31:0] product;
      logic signed [39:0] scaled;
      feature_beat_t      want;
      case (op)
        OP_LOAD_WEIGHT: begin
          if (neuron < N_NEURONS) begin
            weights[pos][neuron] = value;
            weight_known[pos][neuron] = 1'b1;
          end
        end
        OP_LOAD_BIAS: begin
          if (neuron < N_NEURONS) begin
            biases[neuron] = value;
            bias_known[neuron] = 1'b1;
          end
        end
        OP_SAMPLE: begin
          for (int k = 0; k < N_NEURONS; k++) begin
            // The first sample of a pass starts each sum from its bias in Q16.24.
            if (samples_taken == 0) sums[k] = {{12{biases[k][15]}}, biases[k], 12'd0};
            product = value * weights[samples_taken][k];
            sums[k] = sums[k] + product;
          end
          samples_taken++;
          if (samples_taken >= pass_len) begin
            samples_taken = 0;
            for (int k = 0; k < N_NEURONS; k++) begin
              want = '0;
              if (sums[k] > 0) begin
                scaled = sums[k] >>> 12;
                want.feature = (scaled > FEATURE_MAX) ? 15'(FEATURE_MAX) : scaled[14:0];
                want.active = 1'b1;
              end
              want.neuron = 6'(k);
              want.last = (k == N_NEURONS - 1);
              expected_features.push_back(want);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_feature(logic [14:0] feature, logic active, logic [5:0] neuron,
                                logic last);
      feature_beat_t want;
      if (expected_features.size() == 0) begin
        $error("result beat for neuron %0d with nothing expected", neuron);
        failures++;
        return;
      end
      want = expected_features.pop_front();
      if (feature !== want.feature) begin
        $error("feature_value: expected %0d, got %0d", want.feature, feature);
        failures++;
      end
      if (active !== want.active) begin
        $error("active: expected %0d, got %0d", want.active, active);
        failures++;
      end
      if (neuron !== want.neuron) begin
        $error("neuron_number: expected %0d, got %0d", want.neuron, neuron);
        failures++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %0d, got %0d", want.last, last);
        failures++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire  [31:0] prdata;
  wire         pready;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // neuron_index[5:0], input_index[13:6], value[29:14]
  logic [1:0]  s_axis_tuser = '0;   // operation[1:0]
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [23:0] m_axis_tdata;        // feature_value[14:0], active[15], neuron_number[21:16]
  wire         m_axis_tlast;        // last_of_run

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int unsigned sender_gap_pct = 8;
  int unsigned sink_stall_pct = 8;
  // The receiver hold-off is requested by the stimulus and timed by its own process.
  logic        hold_request = 1'b0;
  logic        sink_hold = 1'b0;

  layer_scoreboard sb = new();

  dense_layer_relu_top #(
    .NUM_NEURONS(N_NEURONS),
    .MAX_INPUTS (MAX_IN)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #CLK_HALF clk = ~clk;

  // Receiver: a beat is taken at the edge where valid and ready were both high
  // just before it, then ready is redrawn for the next cycle.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_feature(m_axis_tdata[14:0], m_axis_tdata[15], m_axis_tdata[21:16],
                       m_axis_tlast);
    end
    m_axis_tready <= !sink_hold && ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Long receiver hold-off: once requested, ready is held low while the stimulus
  // keeps offering samples.
  initial begin
    wait (hold_request);
    sink_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    sink_hold <= 1'b0;
  end

  // Run limit, well above the slowest correct run.
  initial begin
    #10_000_000;
    $display("dense_layer_relu_top test failed");
    $finish;
  end

  // Mostly full-range values, with the two extremes and small magnitudes mixed
  // in so that sums land in the middle of the output range as well.
  function automatic logic signed [15:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2, 3: return 16'($urandom_range(0, 255)) - 16'd128;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offers one beat, with random idle cycles in front, and returns at the edge
  // that takes it. Valid stays high so a following beat goes out back to back.
  task automatic send_beat(input logic [1:0] op, input logic [5:0] neuron,
                           input logic [7:0] pos, input logic signed [15:0] value);
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, value, pos, neuron};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_beat(op, neuron, pos, value);
  endtask

  // A sample reads one weight row and, at the start of a pass, every bias.
  // Entries never written are loaded first so that no undefined value is read.
  task automatic send_sample(input logic signed [15:0] value);
    int unsigned row;
    row = sb.samples_taken;
    for (int k = 0; k < N_NEURONS; k++) begin
      if (!sb.bias_known[k]) send_beat(OP_LOAD_BIAS, 6'(k), 8'($urandom), rand_value());
      if (!sb.weight_known[row][k]) send_beat(OP_LOAD_WEIGHT, 6'(k), 8'(row), rand_value());
    end
    send_beat(OP_SAMPLE, 6'($urandom), 8'($urandom), value);
  endtask

  task automatic send_random_item();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) send_sample(rand_value());
    else if (pick < 82) send_beat(OP_LOAD_WEIGHT, 6'($urandom), 8'($urandom), rand_value());
    else if (pick < 95) send_beat(OP_LOAD_BIAS, 6'($urandom), 8'($urandom), rand_value());
    else send_beat(OP_UNUSED, 6'($urandom), 8'($urandom), 16'($urandom));
  endtask

  // Brings the block to rest: input released, every owed beat received, and
  // time for a sample still being swept that owes nothing.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of the samples-per-pass register: setup cycle, then access cycle.
  task automatic write_length(input logic [8:0] len);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_INPUTS_IN_USE;
    pwdata  <= 32'(len);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_length(len);
  endtask

  initial begin
    int unsigned phase_len [6];
    phase_len = '{1, 3, 0, 2, 3, 0};

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    settle();

    // Directed part, one sample per pass. The unused code is dropped.
    write_length(9'd1);
    send_beat(OP_UNUSED, 6'd63, 8'd255, 16'sh8000);
    send_beat(OP_UNUSED, 6'd0, 8'd0, 16'sh7FFF);
    // Neuron 0 saturates, neuron 1 goes far negative, neuron 2 sums to exactly
    // zero, neuron 3 sits on one LSB of output, and neuron 4 is positive but
    // below one output LSB once the sample is one.
    send_beat(OP_LOAD_BIAS, 6'd0, 8'($urandom), 16'sh7FFF);
    send_beat(OP_LOAD_BIAS, 6'd1, 8'($urandom), 16'sh8000);
    send_beat(OP_LOAD_BIAS, 6'd2, 8'($urandom), 16'sh0000);
    send_beat(OP_LOAD_BIAS, 6'd3, 8'($urandom), 16'sh0001);
    send_beat(OP_LOAD_BIAS, 6'd4, 8'($urandom), 16'sh0000);
    send_beat(OP_LOAD_BIAS, 6'd63, 8'($urandom), 16'shFFFF);
    send_beat(OP_LOAD_WEIGHT, 6'd0, 8'd0, 16'sh7FFF);
    send_beat(OP_LOAD_WEIGHT, 6'd1, 8'd0, 16'sh8000);
    send_beat(OP_LOAD_WEIGHT, 6'd2, 8'd0, 16'sh0000);
    send_beat(OP_LOAD_WEIGHT, 6'd3, 8'd0, 16'sh0000);
    send_beat(OP_LOAD_WEIGHT, 6'd4, 8'd0, 16'sh0001);
    send_beat(OP_LOAD_WEIGHT, 6'd63, 8'd255, 16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sh0001);
    send_sample(16'sh8000);
    send_sample(16'sh0000);

    // A register value of zero behaves as one sample per pass.
    settle();
    write_length(9'd0);
    send_sample(rand_value());

    // Loads between samples: a weight change counts for the rest of the pass,
    // a bias change only from the next pass on.
    settle();
    write_length(9'd3);
    send_sample(rand_value());
    send_beat(OP_LOAD_WEIGHT, 6'd5, 8'd1, rand_value());
    send_sample(rand_value());
    send_beat(OP_LOAD_BIAS, 6'd0, 8'($urandom), rand_value());
    send_sample(rand_value());

    // Shortening the pass after two samples ends it on the next sample.
    settle();
    write_length(9'd256);
    repeat (2) send_sample(rand_value());
    settle();
    write_length(9'd1);
    send_sample(rand_value());

    // Random phases over several pass lengths; a phase may stop mid-pass, so
    // the next register write also lands in the middle of a pass. Pass lengths
    // stay at three or below, so only the first three weight rows are read.
    // Phase three runs without any idling on either side.
    for (int p = 0; p < 6; p++) begin
      settle();
      if (p == 5) write_length(9'($urandom_range(1, 3)));
      else write_length(9'(phase_len[p]));
      sender_gap_pct = (p == 3) ? 0 : 8;
      sink_stall_pct = (p == 3) ? 0 : 8;
      repeat (16) send_random_item();
    end

    // Backpressure: the receiver holds off while single-sample passes keep
    // coming, so the block fills its output and stops taking input.
    settle();
    write_length(9'd1);
    hold_request <= 1'b1;
    repeat (6) send_sample(rand_value());

    // A register value above the row count acts as the row count, so two
    // samples leave the pass open; a shorter length then closes it on the
    // next sample.
    settle();
    write_length(9'd511);
    repeat (2) send_sample(rand_value());
    settle();
    write_length(9'd1);
    send_sample(rand_value());

    settle();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("dense_layer_relu_top test passed");
    end else begin
      $display("dense_layer_relu_top test failed");
    end
    $finish;
  end

endmodule
